### design/scs_pkg.sv
// shared types and constants for the sorted categorical sampler
`timescale 1ns / 1ps

package scs_pkg;

  localparam int COUNT_W  = 31;
  localparam int SYM_W    = 8;
  localparam int FRAC_W   = 32;
  localparam int BOUND_W  = 63;
  localparam logic [SYM_W-1:0] MAX_SYMBOL_RESET = 8'hFF;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_ACC   = 5'b10000
  } state_t;

  // control from the sequencer to the selection unit
  typedef struct packed {
    logic valid;
    logic restart;
    logic advance;
  } sel_ctl_t;

endpackage

### design/scs_count_mem.sv
// per-symbol count memory, one write port and one registered read port
`timescale 1ns / 1ps

module scs_count_mem import scs_pkg::*; #(
  parameter int SYMBOLS = 256,
  parameter int AW = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COUNT_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [COUNT_W-1:0] rd_data
);

  logic [COUNT_W-1:0] mem [SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### design/scs_select.sv
// shared compare unit: finds the next symbol in descending count order, stable on ties
`timescale 1ns / 1ps

module scs_select import scs_pkg::*; #(
  parameter int IW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  sel_ctl_t           ctl,
  input  logic [COUNT_W-1:0] rd_count,
  input  logic [IW-1:0]      rd_idx,
  output logic [COUNT_W-1:0] best_count,
  output logic [IW-1:0]      best_idx
);

  logic [COUNT_W-1:0] prev_count;
  logic [IW-1:0]      prev_idx;
  logic               first;
  logic               found;
  logic               cand;

  // candidate comes strictly after the previously visited symbol in sorted order
  assign cand = first || (rd_count < prev_count) ||
                ((rd_count == prev_count) && (rd_idx > prev_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
      found <= 1'b0;
    end else if (ctl.restart) begin
      first <= 1'b1;
      found <= 1'b0;
    end else if (ctl.advance) begin
      first <= 1'b0;
      found <= 1'b0;
    end else if (ctl.valid && cand && (!found || rd_count > best_count)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prev_count <= best_count;
      prev_idx   <= best_idx;
    end
    if (!ctl.restart && !ctl.advance && ctl.valid && cand &&
        (!found || rd_count > best_count)) begin
      best_count <= rd_count;
      best_idx   <= rd_idx;
    end
  end

endmodule

### design/sorted_categorical_sampler_core.sv
// top level: sequencer, count memory and selection unit of the categorical sampler
`timescale 1ns / 1ps

// Draws a symbol from counts by inverse-cdf search in descending count order (ties to the
// lower index). A draw walks the alphabet 0..L, L = min(max_symbol, SYMBOLS-1): each visited
// symbol costs one scan of addresses 0..L of the count memory through its single read port,
// and a draw ends early once the cumulative count reaches the threshold. After reset the
// count memory is cleared with busy high. Each result is shown for one cycle with
// result_valid and cannot be stalled; the block takes the next word in that same cycle.
module sorted_categorical_sampler_core import scs_pkg::*; #(
  parameter int SYMBOLS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [COUNT_W-1:0] count_value,
  input  logic [COUNT_W-1:0] total,
  input  logic [FRAC_W-1:0]  random_fraction,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SYM_W-1:0]   cfg_data,
  output logic               result_valid,
  output logic [SYM_W-1:0]   drawn_symbol,
  output logic               fell_through
);

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int IW = (AW > SYM_W) ? AW : SYM_W;
  localparam logic [IW-1:0] SYM_LAST = IW'(SYMBOLS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(SYMBOLS - 1);

  state_t             state;
  logic [SYM_W-1:0]   max_symbol;
  logic [AW-1:0]      clr_addr;
  logic [IW-1:0]      addr;
  logic [IW-1:0]      step;
  logic [IW-1:0]      lim;
  logic [IW-1:0]      rd_idx;
  logic               rd_valid;
  logic [31:0]        cum;
  logic [BOUND_W-1:0] bound;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] best_count;
  logic [IW-1:0]      best_idx;
  logic [32:0]        cum_sum;
  logic               hit;
  logic               accept;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;
  sel_ctl_t           sel_ctl;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    if (IW'(max_symbol) > SYM_LAST) begin
      lim = SYM_LAST;
    end else begin
      lim = IW'(max_symbol);
    end
  end

  // write port is shared by the clear sweep and set words
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (accept && operation == OP_SET && IW'(symbol) <= SYM_LAST) begin
      wr_en   = 1'b1;
      wr_addr = AW'(symbol);
      wr_data = count_value;
    end
  end

  assign cum_sum = {1'b0, cum} + 33'(best_count);
  // cum_sum * 2^32 >= u * total, saturating once cum_sum reaches 2^32
  assign hit = cum_sum[32] || ({cum_sum[31:0], 32'h0} >= {1'b0, bound});

  assign sel_ctl.valid   = rd_valid;
  assign sel_ctl.restart = accept && operation == OP_DRAW;
  assign sel_ctl.advance = (state == ST_ACC);

  scs_count_mem #(.SYMBOLS(SYMBOLS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr[AW-1:0]),
    .rd_data (rd_count)
  );

  scs_select #(.IW(IW)) u_sel (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sel_ctl),
    .rd_count   (rd_count),
    .rd_idx     (rd_idx),
    .best_count (best_count),
    .best_idx   (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_symbol <= MAX_SYMBOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_symbol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      addr         <= '0;
      step         <= '0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_valid     <= (state == ST_SCAN);
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && operation == OP_DRAW) begin
            addr  <= '0;
            step  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          addr <= addr + 1'b1;
          if (addr == lim) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (hit || step == lim) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            step  <= step + 1'b1;
            addr  <= '0;
            state <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (accept && operation == OP_DRAW) begin
      bound <= BOUND_W'(random_fraction) * BOUND_W'(total);
      cum   <= '0;
    end else if (state == ST_ACC) begin
      cum <= cum_sum[31:0];
    end
    if (state == ST_ACC) begin
      drawn_symbol <= best_idx[SYM_W-1:0];
      fell_through <= !hit;
    end
  end

  a_one_shot: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_from_acc: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_ACC))
    else $error("result strobe without a finished draw");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (addr <= lim) && (step <= lim))
    else $error("scan ran past the last symbol");

  a_clear_busy: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("block ready before the count clear finished");

endmodule
